>>> rtl/sca_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sine/cosine approximation pipeline.
// No dependencies; used by sca_isqrt and sine_cosine_approx.
package sca_pkg;

	// Angles in unsigned Q.32, rounded
	localparam logic [34:0] PI_Q32         = 35'h3243F6A89;
	localparam logic [34:0] HALF_PI_Q32    = 35'h1921FB544;
	localparam logic [34:0] QUARTER_PI_Q32 = 35'h0C90FDAA2;
	localparam logic [34:0] TWO_PI_Q32     = 35'h6487ED511;

	// Octant boundaries at odd multiples of pi/4
	localparam logic [34:0] OCT1_Q32 = QUARTER_PI_Q32;
	localparam logic [34:0] OCT3_Q32 = QUARTER_PI_Q32 + HALF_PI_Q32;
	localparam logic [34:0] OCT5_Q32 = PI_Q32 + QUARTER_PI_Q32;
	localparam logic [34:0] OCT7_Q32 = PI_Q32 + HALF_PI_Q32 + QUARTER_PI_Q32;

	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

	// floor(x / 3) = (x * RECIP3_Q33) >> 33 for any 32-bit x
	localparam logic [31:0] RECIP3_Q33 = 32'hAAAAAAAB;

	// Per-item sideband that rides alongside the square-root pipeline
	typedef struct packed {
		logic [31:0] emag;    // series result, already rounded to output format
		logic        direct;  // series result is the sine
		logic        sneg;
		logic        cneg;
	} sca_side_t;

endpackage

>>> rtl/sca_isqrt.sv
`timescale 1ns / 1ps
// Pipelined rounded integer square root, one result bit per stage.
// Depends on sca_pkg for the sideband struct carried with each item.
module sca_isqrt #(
	parameter int OUT_FRAC_BITS = 30
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [2*OUT_FRAC_BITS:0]     a,
	input  sca_pkg::sca_side_t           side_in,
	output logic                         out_valid,
	output logic [31:0]                  root,
	output sca_pkg::sca_side_t           side_out
);
	import sca_pkg::*;

	localparam int AW = 2 * OUT_FRAC_BITS + 1;
	localparam int RW = AW + 1;
	localparam int ST = OUT_FRAC_BITS + 1;

	logic [AW-1:0] v_s   [0:ST];
	logic [RW-1:0] r_s   [0:ST];
	logic          vld_s [0:ST];
	sca_side_t     sd_s  [0:ST];

	logic          vld_q;
	logic [31:0]   root_q;
	sca_side_t     side_q;

	assign v_s[0]   = a;
	assign r_s[0]   = '0;
	assign vld_s[0] = in_valid;
	assign sd_s[0]  = side_in;

	for (genvar i = 0; i < ST; i++) begin : g_step
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (OUT_FRAC_BITS - i));
		logic [RW-1:0] trial;
		logic          take;

		assign trial = r_s[i] + BIT;
		assign take  = {1'b0, v_s[i]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (take) begin
					v_s[i+1] <= AW'({1'b0, v_s[i]} - trial);
					r_s[i+1] <= (r_s[i] >> 1) + BIT;
				end else begin
					v_s[i+1] <= v_s[i];
					r_s[i+1] <= r_s[i] >> 1;
				end
				sd_s[i+1] <= sd_s[i];
			end
		end
	end

	// Round to nearest: bump when the remainder exceeds the root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_s[ST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_q <= 32'(r_s[ST] + RW'({1'b0, v_s[ST]} > r_s[ST]));
			side_q <= sd_s[ST];
		end
	end

	assign out_valid = vld_q;
	assign root      = root_q;
	assign side_out  = side_q;

endmodule

>>> rtl/sine_cosine_approx.sv
`timescale 1ns / 1ps
// Sine and cosine approximation of a fixed-point angle.
// Depends on sca_pkg and sca_isqrt.
//
// Usage:
//   Slave channel (s_tvalid/s_tready/s_tdata) takes one signed angle per
//   transfer, ANGLE_FRAC_BITS fraction bits. Master channel gives one transfer
//   per angle: sine in the low 32 bits of m_tdata, cosine in the high 32 bits,
//   each signed with OUT_FRAC_BITS fraction bits, in input order.
//   Throughput: one angle per cycle while s_tready is high. From accepted
//   input to m_tvalid the path runs through one stage per quotient bit of
//   the modulo-2*pi reduction, eight stages for octant selection and the
//   polynomial, and one stage per result bit of the square root.
//   When the receiver stalls, the finished result holds in the output
//   register and one more result parks in a skid register; only then does
//   s_tready drop and the whole pipeline hold. Nothing is dropped or repeated.
//   Reset clears all valid bits; the block accepts input in the first cycle
//   after reset is released.
module sine_cosine_approx #(
	parameter int ANGLE_FRAC_BITS = 24,
	parameter int OUT_FRAC_BITS   = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] angle
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // [31:0] sine_value, [63:32] cosine_value
);
	import sca_pkg::*;

	localparam int AX_W = 64 - ANGLE_FRAC_BITS;
	localparam int QB   = AX_W - 34;
	localparam int ESH  = 32 - OUT_FRAC_BITS;
	localparam int SH   = 64 - 2 * OUT_FRAC_BITS;
	localparam int AW   = 2 * OUT_FRAC_BITS + 1;
	localparam int LIM  = 1 << OUT_FRAC_BITS;

	logic en;

	// ---------------- magnitude and modulo-2*pi reduction ----------------
	logic [31:0]     amag;
	logic [AX_W-1:0] rd_n_s   [0:QB];
	logic            rd_v_s   [0:QB];
	logic            rd_neg_s [0:QB];

	assign amag = s_tdata[31] ? 32'(32'd0 - s_tdata) : s_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s[0] <= 1'b0;
		end else if (en) begin
			rd_v_s[0] <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_n_s[0]   <= AX_W'(amag) << (32 - ANGLE_FRAC_BITS);
			rd_neg_s[0] <= s_tdata[31];
		end
	end

	// Restoring reduction: one quotient bit per stage, largest first
	for (genvar k = 0; k < QB; k++) begin : g_red
		localparam logic [AX_W-1:0] SUB = AX_W'(TWO_PI_Q32) << (QB - 1 - k);
		logic ge;

		assign ge = rd_n_s[k] >= SUB;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rd_v_s[k+1] <= 1'b0;
			end else if (en) begin
				rd_v_s[k+1] <= rd_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rd_n_s[k+1]   <= ge ? rd_n_s[k] - SUB : rd_n_s[k];
				rd_neg_s[k+1] <= rd_neg_s[k];
			end
		end
	end

	// ---------------- octant selection ----------------
	logic [34:0] n;
	logic [34:0] bias;
	logic [34:0] delta;
	logic        dir_c;
	logic        sneg_c;
	logic        cneg_c;

	assign n = rd_n_s[QB][34:0];

	always_comb begin
		if (n < OCT1_Q32) begin
			bias  = '0;
			dir_c = 1'b0;
		end else if (n < OCT3_Q32) begin
			bias  = HALF_PI_Q32;
			dir_c = 1'b1;
		end else if (n < OCT5_Q32) begin
			bias  = PI_Q32;
			dir_c = 1'b0;
		end else if (n < OCT7_Q32) begin
			bias  = PI_Q32 + HALF_PI_Q32;
			dir_c = 1'b1;
		end else begin
			bias  = TWO_PI_Q32;
			dir_c = 1'b0;
		end
		delta = (n >= bias) ? n - bias : bias - n;

		if (n < HALF_PI_Q32) begin
			sneg_c = 1'b0;
			cneg_c = 1'b0;
		end else if (n < PI_Q32) begin
			sneg_c = 1'b0;
			cneg_c = 1'b1;
		end else if (n < PI_Q32 + HALF_PI_Q32) begin
			sneg_c = 1'b1;
			cneg_c = 1'b1;
		end else begin
			sneg_c = 1'b1;
			cneg_c = 1'b0;
		end
		// a negative angle mirrors the sine, except where the reduced angle is zero
		if (rd_neg_s[QB] && (n != '0)) begin
			sneg_c = !sneg_c;
		end
	end

	// ---------------- series pipeline ----------------
	logic        v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic [31:0] b_s2;
	logic [63:0] bb_s3;
	logic [30:0] h_s4, h_s5, h_s6;
	logic [61:0] hh_s5;
	logic [62:0] prod_s6;
	logic [32:0] e_s7;
	logic [63:0] ee_s8;
	logic        ege_s8, ez_s8;
	logic [AW-1:0] a_s9;
	sca_side_t   sd_s2, sd_s3, sd_s4, sd_s5, sd_s6, sd_s7, sd_s8, sd_s9;

	logic [63:0] bb_c;
	logic [64:0] hsum_c;
	logic [61:0] hh_c;
	logic [62:0] h2sum_c;
	logic [31:0] xsum_c;
	logic [62:0] prod_c;
	logic [29:0] q_c;
	logic [32:0] e_c;
	logic [33:0] er_c;
	logic [65:0] ee_c;
	logic [63:0] t_c;
	logic [AW-1:0] a_c;

	assign bb_c    = b_s2 * b_s2;
	assign hsum_c  = {1'b0, bb_s3} + 65'(ONE_Q32);
	assign hh_c    = h_s4 * h_s4;
	assign h2sum_c = {1'b0, hh_s5} + (63'd1 << 31);
	assign xsum_c  = {1'b0, h2sum_c[62:32]} + 32'd3;
	// (h2 + 3) / 6 taken as ((h2 + 3) >> 1) / 3
	assign prod_c  = xsum_c[31:1] * RECIP3_Q33;
	assign q_c     = prod_s6[62:33];
	assign e_c     = ONE_Q32 - {2'b0, h_s6} + {3'b0, q_c};
	assign er_c    = {1'b0, e_s7} + (34'd1 << (ESH - 1));
	assign ee_c    = e_s7 * e_s7;
	assign t_c     = 64'd0 - ee_s8;

	always_comb begin
		if (ege_s8) begin
			a_c = '0;
		end else if (ez_s8) begin
			a_c = AW'(1) << (2 * OUT_FRAC_BITS);
		end else begin
			a_c = AW'(t_c >> SH) + AW'(t_c[SH-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s2 <= rd_v_s[QB];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s2         <= delta[31:0];
			sd_s2.emag   <= '0;
			sd_s2.direct <= dir_c;
			sd_s2.sneg   <= sneg_c;
			sd_s2.cneg   <= cneg_c;

			bb_s3   <= bb_c;
			sd_s3   <= sd_s2;

			h_s4    <= hsum_c[63:33];
			sd_s4   <= sd_s3;

			hh_s5   <= hh_c;
			h_s5    <= h_s4;
			sd_s5   <= sd_s4;

			prod_s6 <= prod_c;
			h_s6    <= h_s5;
			sd_s6   <= sd_s5;

			e_s7    <= e_c;
			sd_s7   <= sd_s6;

			ee_s8        <= ee_c[63:0];
			ege_s8       <= e_s7[32];
			ez_s8        <= (e_s7 == '0);
			sd_s8.emag   <= 32'(er_c >> ESH);
			sd_s8.direct <= sd_s7.direct;
			sd_s8.sneg   <= sd_s7.sneg;
			sd_s8.cneg   <= sd_s7.cneg;

			a_s9    <= a_c;
			sd_s9   <= sd_s8;
		end
	end

	// ---------------- square root of the complement ----------------
	logic        sq_valid;
	logic [31:0] sq_root;
	sca_side_t   sq_side;

	sca_isqrt #(
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s9),
		.a        (a_s9),
		.side_in  (sd_s9),
		.out_valid(sq_valid),
		.root     (sq_root),
		.side_out (sq_side)
	);

	// ---------------- sign assembly and output skid ----------------
	logic [31:0] smag, cmag;
	logic [63:0] res_c;
	logic        ov_q, kv_q;
	logic [63:0] out_q, skid_q;

	assign smag  = sq_side.direct ? sq_side.emag : sq_root;
	assign cmag  = sq_side.direct ? sq_root : sq_side.emag;
	assign res_c = {sq_side.cneg ? 32'd0 - cmag : cmag,
	                sq_side.sneg ? 32'd0 - smag : smag};

	assign en       = !kv_q;
	assign s_tready = en;
	assign m_tvalid = ov_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			kv_q <= 1'b0;
		end else if (!ov_q || m_tready) begin
			ov_q <= kv_q | sq_valid;
			kv_q <= 1'b0;
		end else if (sq_valid && !kv_q) begin
			kv_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ov_q || m_tready) begin
			out_q <= kv_q ? skid_q : res_c;
		end else if (!kv_q) begin
			skid_q <= res_c;
		end
	end

	// ---------------- assertions ----------------
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		kv_q |-> ov_q)
		else $error("skid register full while output register empty");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		kv_q && !m_tready |=> kv_q)
		else $error("skid entry lost during output stall");

	a_sine_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[31:0]) <= LIM && $signed(m_tdata[31:0]) >= -LIM))
		else $error("sine magnitude out of range");

	a_cosine_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[63:32]) <= LIM && $signed(m_tdata[63:32]) >= -LIM))
		else $error("cosine magnitude out of range");

endmodule
